FILE: design/gaevt_pkg.sv
// Package: payload types, sequencer states, register map and Q16.16 helpers.
`timescale 1ns / 1ps

package gaevt_pkg;

   localparam logic [16:0] Q_ONE  = 17'd65536;
   localparam logic [16:0] Q_HALF = 17'd32768;

   localparam logic [16:0] DISCOUNT_RST    = 17'd64881;
   localparam logic [16:0] TRACE_DECAY_RST = 17'd62259;
   localparam logic [23:0] DELTA_CLIP_RST  = 24'd65536;
   localparam logic [23:0] TRACE_CLIP_RST  = 24'd65536;

   // register index = paddr[3:2]
   localparam logic [1:0] REG_DISCOUNT    = 2'd0;
   localparam logic [1:0] REG_TRACE_DECAY = 2'd1;
   localparam logic [1:0] REG_DELTA_CLIP  = 2'd2;
   localparam logic [1:0] REG_TRACE_CLIP  = 2'd3;

   typedef struct packed {
      logic               row_start;
      logic               row_end;
      logic signed [31:0] state_value;
      logic signed [31:0] reward;
      logic               done_req;
      logic [23:0]        weight;
   } req_type;

   typedef struct packed {
      logic signed [31:0] advantage;
      logic               row_last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GL,
      S_GV,
      S_GLC,
      S_INNER,
      S_TR,
      S_DELTA,
      S_CAPT,
      S_ADV,
      S_OUT
   } state_type;

   // saturate a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat_q32(input logic signed [41:0] x);
      logic signed [31:0] r;
      if (x[41:31] == {11{x[41]}}) begin
         r = x[31:0];
      end else if (x[41]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

FILE: design/gaevt_qmul.sv
// Shared two-stage Q16.16 multiplier: exact product, round half up, saturate.
`timescale 1ns / 1ps

module gaevt_qmul
   import gaevt_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic        [23:0] op_b,
   output logic signed [31:0] res
);

   logic [56:0]        prod_in;
   logic [56:0]        prod_ff;
   logic [57:0]        rnd;
   logic signed [31:0] res_in;
   logic signed [31:0] res_ff;

   // modulo-2^57 product of the sign-extended operands is the exact signed product
   assign prod_in = {{25{op_a[31]}}, op_a} * {33'b0, op_b};

   assign rnd    = {prod_ff[56], prod_ff} + {41'b0, Q_HALF};
   assign res_in = sat_q32(rnd[57:16]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

FILE: design/gae_vtrace_advantage_core.sv
// Top level: GAE advantage with V-trace clipped weights, sequenced over one multiplier.
`timescale 1ns / 1ps

// Time steps of a row arrive last first. A row_start item only latches its
// value, reward and done flag and clears the running advantage; it leaves
// the sequencer idle and gives no result. Every other item gives one result. Its
// five dependent products (gamma*lambda, gamma*v_next, that*c, trace*adv,
// rho*inner) all go through one shared multiplier with two register stages,
// so an item runs through states GL..ADV from acceptance to the result
// register and req_stall is high during that time; the next item is taken
// only back in IDLE, after the result is written. The
// result sits in an output register, so the next item is accepted while it
// waits; only if that register is still full when the next result is ready
// does the sequencer hold in OUT. Configuration is over an APB-style port,
// registers at byte addresses 0, 4, 8, 12; discount and decay above 1.0 are
// used as 1.0.
module gae_vtrace_advantage_core
   import gaevt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type state_ff, state_in;

   // config registers
   logic [16:0] discount_ff;
   logic [16:0] trace_decay_ff;
   logic [23:0] delta_clip_ff;
   logic [23:0] trace_clip_ff;
   logic [16:0] gamma;
   logic [16:0] lambda;

   // recurrence state
   logic signed [31:0] next_value_ff;
   logic signed [31:0] next_reward_ff;
   logic               next_live_ff;
   logic signed [31:0] running_adv_ff;

   // item in flight
   logic signed [31:0] cur_value_ff;
   logic signed [31:0] cur_reward_ff;
   logic               cur_done_ff;
   logic               cur_end_ff;
   logic [23:0]        rho_ff;
   logic [23:0]        c_ff;
   logic [23:0]        rho_in;
   logic [23:0]        c_in;

   // intermediates
   logic signed [31:0] inner_ff;
   logic signed [31:0] tr_ff;
   logic [33:0]        inner_sum;
   logic [32:0]        adv_sum;
   logic signed [31:0] adv_in;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic        [23:0] mul_b;
   logic signed [31:0] mul_res;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic req_accept;
   logic out_free;
   logic cfg_write;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   assign gamma  = (discount_ff > Q_ONE) ? Q_ONE : discount_ff;
   assign lambda = (trace_decay_ff > Q_ONE) ? Q_ONE : trace_decay_ff;

   assign rho_in = (req_data.weight < delta_clip_ff) ? req_data.weight : delta_clip_ff;
   assign c_in   = (req_data.weight < trace_clip_ff) ? req_data.weight : trace_clip_ff;

   // r_next + gamma*v_next*live - v ; multiplier output holds gamma*v_next in INNER
   assign inner_sum = {{2{next_reward_ff[31]}}, next_reward_ff}
                    + (next_live_ff ? {{2{mul_res[31]}}, mul_res} : 34'b0)
                    - {{2{cur_value_ff[31]}}, cur_value_ff};
   // delta + trace term ; multiplier output holds delta in ADV
   assign adv_sum   = {mul_res[31], mul_res} + {tr_ff[31], tr_ff};
   assign adv_in    = sat_q32({{9{adv_sum[32]}}, adv_sum});

   gaevt_qmul u_qmul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .res   (mul_res)
   );

   // register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DISCOUNT:    csr_prdata = {15'b0, discount_ff};
         REG_TRACE_DECAY: csr_prdata = {15'b0, trace_decay_ff};
         REG_DELTA_CLIP:  csr_prdata = {8'b0, delta_clip_ff};
         REG_TRACE_CLIP:  csr_prdata = {8'b0, trace_clip_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff    <= DISCOUNT_RST;
         trace_decay_ff <= TRACE_DECAY_RST;
         delta_clip_ff  <= DELTA_CLIP_RST;
         trace_clip_ff  <= TRACE_CLIP_RST;
      end else if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_DISCOUNT:    discount_ff    <= csr_pwdata[16:0];
            REG_TRACE_DECAY: trace_decay_ff <= csr_pwdata[16:0];
            REG_DELTA_CLIP:  delta_clip_ff  <= csr_pwdata[23:0];
            REG_TRACE_CLIP:  trace_clip_ff  <= csr_pwdata[23:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: each product reaches mul_res through the multiplier's prod_ff and res_ff registers
   always_comb begin
      state_in = state_ff;
      mul_a    = inner_ff;
      mul_b    = rho_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && !req_data.row_start) begin
               state_in = S_GL;
            end
         end
         S_GL: begin
            mul_a    = {15'b0, lambda};
            mul_b    = {7'b0, gamma};
            state_in = S_GV;
         end
         S_GV: begin
            mul_a    = next_value_ff;
            mul_b    = {7'b0, gamma};
            state_in = S_GLC;
         end
         S_GLC: begin
            mul_a    = mul_res;            // gamma*lambda, within 0..1.0
            mul_b    = c_ff;
            state_in = S_INNER;
         end
         S_INNER: begin
            state_in = S_TR;
         end
         S_TR: begin
            mul_a    = running_adv_ff;
            mul_b    = mul_res[23:0];      // gamma*lambda*c, below 2^24
            state_in = S_DELTA;
         end
         S_DELTA: begin
            mul_a    = inner_ff;
            mul_b    = rho_ff;
            state_in = S_CAPT;
         end
         S_CAPT: begin
            state_in = S_ADV;
         end
         S_ADV: begin
            state_in = out_free ? S_IDLE : S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_value_ff  <= req_data.state_value;
         cur_reward_ff <= req_data.reward;
         cur_done_ff   <= req_data.done_req;
         cur_end_ff    <= req_data.row_end;
         rho_ff        <= rho_in;
         c_ff          <= c_in;
      end
      if (state_ff == S_INNER) begin
         inner_ff <= sat_q32({{8{inner_sum[33]}}, inner_sum});
      end
      if (state_ff == S_CAPT) begin
         tr_ff <= next_live_ff ? mul_res : 32'sd0;
      end
   end

   // recurrence state
   always_ff @(posedge clock) begin
      if (reset) begin
         next_value_ff  <= 32'sd0;
         next_reward_ff <= 32'sd0;
         next_live_ff   <= 1'b0;
         running_adv_ff <= 32'sd0;
      end else if (req_accept && req_data.row_start) begin
         next_value_ff  <= req_data.state_value;
         next_reward_ff <= req_data.reward;
         next_live_ff   <= !req_data.done_req;
         running_adv_ff <= 32'sd0;
      end else if (state_ff == S_ADV) begin
         next_value_ff  <= cur_value_ff;
         next_reward_ff <= cur_reward_ff;
         next_live_ff   <= !cur_done_ff;
         running_adv_ff <= adv_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_ADV || state_ff == S_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ADV && out_free) begin
         rsp_ff.advantage <= adv_in;
         rsp_ff.row_last  <= cur_end_ff;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_ff.advantage <= running_adv_ff;
         rsp_ff.row_last  <= cur_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> state_ff == S_IDLE)
      else $error("item accepted while sequencer busy");

   a_start_clears_adv: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.row_start |=> running_adv_ff == 32'sd0 && state_ff == S_IDLE)
      else $error("row start did not clear running advantage");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_ADV || $past(state_ff) == S_OUT)
      else $error("result raised outside of ADV/OUT");

   a_gl_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GLC |-> !mul_res[31] && mul_res <= 32'sd65536)
      else $error("gamma*lambda out of range");
`endif

endmodule

FILE: sim/tb_gae_vtrace_advantage_core.sv
// Testbench for gae_vtrace_advantage_core: a Q16.16 predictor checks every result item.
`timescale 1ns / 1ps

// Stimulus and checking:
//  - an initial block fills pending_items with input items: a directed set first,
//    then random rows (row_start item, body, row_end item) with some noise mixed in
//  - the driver offers items from pending_items; on every accepted item it runs
//    predict_advantage, which keeps its own copy of the row state and the
//    registers and queues the expected result item, if there is one
//  - the monitor pops the oldest expectation on each accepted result item and
//    compares it field by field
//  - registers are written only when nothing is in flight, through the
//    APB-style port, with several settings including the extremes
//  - one long receiver hold fills the block and backs up its input
module tb_gae_vtrace_advantage_core
   import gaevt_pkg::*;
();

   localparam int     HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int     STUCK_LIMIT  = 3000;  // cycles with nothing accepted
   localparam int     SETTLE_WAIT  = 30;    // wait after draining, past the sequencer and output reg
   localparam longint WORD_MAX     = 64'sd2147483647;
   localparam longint WORD_MIN     = -64'sd2147483648;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // items waiting to be offered, results waiting to arrive
   req_type     pending_items[$];
   rsp_type     advantage_exp[$];

   // idle percentages of each side, set per phase
   int unsigned tx_idle_pct = 10;
   int unsigned rx_idle_pct = 69;

   // long hold-off: the initial block asks, the hold process serves
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   int unsigned fail_count = 0;
   int unsigned stuck_cycles = 0;

   // predictor's copy of the registers
   logic [16:0] discount_cfg    = DISCOUNT_RST;
   logic [16:0] decay_cfg       = TRACE_DECAY_RST;
   logic [23:0] delta_clip_cfg  = DELTA_CLIP_RST;
   logic [23:0] trace_clip_cfg  = TRACE_CLIP_RST;

   // predictor's copy of the row state
   logic signed [31:0] next_value  = '0;
   logic signed [31:0] next_reward = '0;
   logic               next_live   = 1'b0;
   logic signed [31:0] running_adv = '0;

   gae_vtrace_advantage_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [31:0] sat_word(input longint x);
      if (x > WORD_MAX) begin
         return 32'sh7FFF_FFFF;
      end
      if (x < WORD_MIN) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   // exact product, round half up, drop 16 fraction bits, saturate
   function automatic logic signed [31:0] q16_mul(input longint a, input longint b);
      longint p;
      p = a * b + 64'sd32768;
      return sat_word(p >>> 16);
   endfunction

   // one time step of the row recurrence; returns 1 when a result item is due
   function automatic bit predict_advantage(input req_type item, output rsp_type res);
      longint             g, l, rho, c, v;
      logic signed [31:0] gv, inner, delta, gl, glc, trace;
      bit                 has;
      res = '0;
      has = 1'b0;
      v = longint'($signed(item.state_value));
      if (item.row_start) begin
         running_adv = '0;
      end else begin
         // discount and decay above one act as one
         g = (discount_cfg > Q_ONE) ? longint'(Q_ONE) : longint'(discount_cfg);
         l = (decay_cfg > Q_ONE) ? longint'(Q_ONE) : longint'(decay_cfg);
         rho = (item.weight < delta_clip_cfg) ? longint'(item.weight)
                                              : longint'(delta_clip_cfg);
         c = (item.weight < trace_clip_cfg) ? longint'(item.weight)
                                            : longint'(trace_clip_cfg);
         gv = next_live ? q16_mul(g, longint'(next_value)) : 32'sd0;
         inner = sat_word(longint'(next_reward) + longint'(gv) - v);
         delta = q16_mul(rho, longint'(inner));
         gl = q16_mul(g, l);
         glc = q16_mul(longint'(gl), c);
         trace = next_live ? q16_mul(longint'(glc), longint'(running_adv)) : 32'sd0;
         running_adv = sat_word(longint'(delta) + longint'(trace));
         res.advantage = running_adv;
         res.row_last = item.row_end;
         has = 1'b1;
      end
      next_value = item.state_value;
      next_reward = item.reward;
      next_live = !item.done_req;
      return has;
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : item_driver
      rsp_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (predict_advantage(req_data, res)) begin
               advantage_exp.push_back(res);
            end
         end
         // new item only when the slot is free; a held item stays put
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (advantage_exp.size() == 0) begin
               $error("unexpected result item: advantage %0d row_last %0b",
                      $signed(rsp_data.advantage), rsp_data.row_last);
               fail_count++;
            end else begin
               want = advantage_exp.pop_front();
               if (rsp_data.advantage !== want.advantage) begin
                  $error("advantage: expected %0d, got %0d",
                         $signed(want.advantage), $signed(rsp_data.advantage));
                  fail_count++;
               end
               if (rsp_data.row_last !== want.row_last) begin
                  $error("row_last: expected %0b, got %0b", want.row_last,
                         rsp_data.row_last);
                  fail_count++;
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // watchdog: nothing accepted on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic req_type step_item(input bit start, input bit last,
                                         input logic [31:0] v, input logic [31:0] r,
                                         input bit done, input logic [23:0] w);
      req_type item;
      item.row_start = start;
      item.row_end = last;
      item.state_value = v;
      item.reward = r;
      item.done_req = done;
      item.weight = w;
      return item;
   endfunction

   // mostly modest Q16.16 values, some extremes and full-range words
   function automatic logic [31:0] rand_q16();
      case ($urandom_range(15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom();
         default: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
      endcase
   endfunction

   // importance ratio, mostly near 1.0
   function automatic logic [23:0] rand_weight();
      case ($urandom_range(9))
         0:       return 24'h00_0000;
         1:       return 24'hFF_FFFF;
         2, 3:    return 24'($urandom());
         default: return 24'($urandom_range(0, 32'h2_8000));
      endcase
   endfunction

   // well-formed rows with random content; about one pick in ten is a single noise item
   task automatic queue_rows(input int n);
      int len;
      int left;
      left = n;
      while (left > 0) begin
         if ($urandom_range(9) == 0) begin
            pending_items.push_back(step_item(1'($urandom_range(1)),
                                              1'($urandom_range(1)),
                                              rand_q16(), rand_q16(),
                                              1'($urandom_range(1)), rand_weight()));
            left--;
         end else begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               pending_items.push_back(step_item(k == 0, k == len - 1,
                                                 rand_q16(), rand_q16(),
                                                 $urandom_range(7) == 0,
                                                 rand_weight()));
            end
            left -= len;
         end
      end
   endtask

   // wait until nothing is in flight, then for the block's own latency
   task automatic settle();
      while (pending_items.size() != 0 || req_valid || advantage_exp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // setup cycle, access cycle; pready is always high
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DISCOUNT:    discount_cfg = value[16:0];
         REG_TRACE_DECAY: decay_cfg = value[16:0];
         REG_DELTA_CLIP:  delta_clip_cfg = value[23:0];
         REG_TRACE_CLIP:  trace_clip_cfg = value[23:0];
      endcase
   endtask

   task automatic random_phase(input int unsigned tx, input int unsigned rx,
                               input logic [31:0] gamma, input logic [31:0] lambda,
                               input logic [31:0] delta_clip, input logic [31:0] c_clip,
                               input bit hold, input int n);
      settle();
      csr_write(REG_DISCOUNT, gamma);
      csr_write(REG_TRACE_DECAY, lambda);
      csr_write(REG_DELTA_CLIP, delta_clip);
      csr_write(REG_TRACE_CLIP, c_clip);
      tx_idle_pct <= tx;
      rx_idle_pct <= rx;
      if (hold) begin
         hold_asked <= hold_asked + 1;
      end
      queue_rows(n);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed items, reset register values
      // steps before any row start use the reset state (stored step terminal)
      pending_items.push_back(step_item(0, 0, 32'h0001_8000, 32'h0002_0000, 0, 24'h01_0000));
      pending_items.push_back(step_item(0, 0, 32'hFFFF_0000, 32'h0000_4000, 0, 24'h00_8000));
      // row of a single step: stored, no result
      pending_items.push_back(step_item(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1, 24'hFF_FFFF));
      pending_items.push_back(step_item(0, 0, 32'h0000_1000, 32'h0001_0000, 0, 24'h01_8000));
      // extremes, products and sums saturate
      pending_items.push_back(step_item(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 24'hFF_FFFF));
      pending_items.push_back(step_item(0, 0, 32'h8000_0000, 32'h8000_0000, 0, 24'hFF_FFFF));
      pending_items.push_back(step_item(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 24'hFF_FFFF));
      pending_items.push_back(step_item(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 24'h00_0000));
      pending_items.push_back(step_item(0, 1, 32'h0000_0000, 32'h0000_0000, 0, 24'hAA_AAAA));
      // steps past a row end, no new start
      pending_items.push_back(step_item(0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 0, 24'h55_5555));
      pending_items.push_back(step_item(0, 1, 32'hFFFF_FFFF, 32'h0000_0001, 1, 24'h00_0001));
      // ordinary row with a terminal step inside
      pending_items.push_back(step_item(1, 0, 32'h0003_0000, 32'h0001_0000, 0, 24'h01_0000));
      pending_items.push_back(step_item(0, 0, 32'h0002_8000, 32'h0000_8000, 0, 24'h00_C000));
      pending_items.push_back(step_item(0, 0, 32'hFFFE_0000, 32'hFFFF_8000, 1, 24'h02_0000));
      pending_items.push_back(step_item(0, 0, 32'h0001_0000, 32'h0000_0000, 0, 24'h01_0000));
      pending_items.push_back(step_item(0, 1, 32'h0000_8000, 32'h0000_0000, 0, 24'h00_FFFF));

      // gamma above one, widest clips, long receiver hold
      random_phase(10, 69, 32'h0001_FFFF, 32'h0001_0000, 32'h00FF_FFFF, 32'h00FF_FFFF,
                   1'b1, 150);
      // everything zero
      random_phase(69, 10, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   1'b0, 150);
      // random words, upper bits beyond each register width included
      random_phase(69, 10, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0, 150);
      // back to reset values, lambda above one, wider trace clip
      random_phase(0, 0, 32'(DISCOUNT_RST), 32'h0001_FFFF, 32'(DELTA_CLIP_RST),
                   32'h0001_8000, 1'b0, 150);
      random_phase(0, 0, $urandom(), $urandom(), $urandom_range(0, 32'h3_0000),
                   $urandom_range(0, 32'h3_0000), 1'b0, 150);

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
